@@ sv/tkpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_pkg
// shared types, codes and widths for the touch key press classifier
// ----------------------------------------------------------------------------
package tkpc_pkg;

    // key count and derived index width
    localparam int NUM_KEYS  = 5;
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // field widths
    localparam int KEY_W    = 3;
    localparam int SAMPLE_W = 15;
    localparam int THR_W    = 15;
    localparam int STEP_W   = 8;
    localparam int HOLD_W   = 16;
    localparam int ST_W     = 2;
    localparam int EV_W     = 2;
    localparam int OP_W     = 2;

    // register map
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STEP      = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(1000);
    localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(10);
    localparam logic [HOLD_W-1:0] LIMIT_RST     = HOLD_W'(500);

    // input command codes
    localparam logic CMD_POLL      = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    // classified operation codes
    localparam logic [OP_W-1:0] OP_SKIP      = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL      = 2'd1;
    localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd2;

    // per-key press state
    localparam logic [ST_W-1:0] ST_RELEASED  = 2'd0;
    localparam logic [ST_W-1:0] ST_HOLDING   = 2'd1;
    localparam logic [ST_W-1:0] ST_LONG_HOLD = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    key;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [STEP_W-1:0] step;
        logic [HOLD_W-1:0] limit;
    } cfg_t;

    function automatic logic [KEY_IDX_W-1:0] key_index(input logic [KEY_W-1:0] key);
        return KEY_IDX_W'(key);
    endfunction

    function automatic logic key_in_range(input logic [KEY_W-1:0] key);
        return (32'(key) < NUM_KEYS);
    endfunction

endpackage

@@ sv/touch_key_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_key_press_classifier
// capacitive touch key short and long press classifier
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tuser command, s_tdata key, sample
// m_*       out  m_tvalid / m_tready       m_tdata event_key, event_res, touched
// apb       in   psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// one beat per cycle sustained while m_tready stays high; each beat gives
// exactly one result beat, which passes the input stage, the queue and the
// result register of the state update stage before m_tvalid rises
// the per-key state update is a read-modify-write in the back stage that is
// written as the beat is taken, so beats for one key may follow without gaps
// reset clears all baselines, hold times and press states at once
// a stall on m_* fills the result register, then the queue, then the input
// stage; s_tready drops only once all of them hold a beat
//
module touch_key_press_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [2:0] key, [17:3] sample
    input  logic                                s_tuser,   // [0] command
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [2:0] event_key,
                                                           // [4:3] event_res, [5] touched
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tkpc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // configuration registers
    logic [tkpc_pkg::THR_W-1:0]  threshold_reg;
    logic [tkpc_pkg::STEP_W-1:0] step_reg;
    logic [tkpc_pkg::HOLD_W-1:0] limit_reg;
    logic                        cfg_write;
    logic [1:0]                  reg_sel;
    tkpc_pkg::cfg_t              cfg;

    // front to queue
    logic                        f_valid;
    logic                        f_ready;
    tkpc_pkg::item_t             f_item;

    // queue to back
    logic                        q_valid;
    logic                        q_ready;
    tkpc_pkg::item_t             q_item;

    // result fields
    logic [tkpc_pkg::KEY_W-1:0]  res_key;
    logic [tkpc_pkg::EV_W-1:0]   res_event;
    logic                        res_touched;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tkpc_pkg::THRESHOLD_RST;
            step_reg      <= tkpc_pkg::STEP_RST;
            limit_reg     <= tkpc_pkg::LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                tkpc_pkg::REG_THRESHOLD: threshold_reg <= pwdata[tkpc_pkg::THR_W-1:0];
                tkpc_pkg::REG_STEP:      step_reg      <= pwdata[tkpc_pkg::STEP_W-1:0];
                tkpc_pkg::REG_LIMIT:     limit_reg     <= pwdata[tkpc_pkg::HOLD_W-1:0];
                default:                 ;  // unmapped address, write dropped
            endcase
        end
    end

    // register readback, unmapped addresses read as zero
    always_comb
    begin
        unique case (reg_sel)
            tkpc_pkg::REG_THRESHOLD: prdata = 32'(threshold_reg);
            tkpc_pkg::REG_STEP:      prdata = 32'(step_reg);
            tkpc_pkg::REG_LIMIT:     prdata = 32'(limit_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.step      = step_reg;
    assign cfg.limit     = limit_reg;

    // front: take the beat and tag it poll, calibrate or out-of-range skip
    tkpc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_key     (s_tdata[2:0]),
        .in_sample  (s_tdata[17:3]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_item   (f_item)
    );

    // decoupling queue between the two halves
    tkpc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // back: per-key state update and result register
    tkpc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_key     (res_key),
        .res_event   (res_event),
        .res_touched (res_touched)
    );

    assign m_tdata = {2'b00, res_touched, res_event, res_key};

endmodule

@@ sv/tkpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_front
// input stage: takes a beat, classifies it and hands it to the queue
// ----------------------------------------------------------------------------
module tkpc_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               in_command,
    input  logic [tkpc_pkg::KEY_W-1:0]         in_key,
    input  logic [tkpc_pkg::SAMPLE_W-1:0]      in_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tkpc_pkg::item_t                    out_item
);

    logic            valid_reg;
    logic            valid_next;
    tkpc_pkg::item_t item_reg;
    tkpc_pkg::item_t item_next;
    logic            take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        item_next.key    = in_key;
        item_next.sample = in_sample;
        priority if (!tkpc_pkg::key_in_range(in_key))
            item_next.op = tkpc_pkg::OP_SKIP;
        else if (in_command == tkpc_pkg::CMD_CALIBRATE)
            item_next.op = tkpc_pkg::OP_CALIBRATE;
        else
            item_next.op = tkpc_pkg::OP_POLL;
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/tkpc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module tkpc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tkpc_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tkpc_pkg::item_t pop_item
);

    tkpc_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ sv/tkpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_back
// per-key baseline and press state update, result register
// ----------------------------------------------------------------------------
module tkpc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tkpc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tkpc_pkg::item_t               in_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [tkpc_pkg::KEY_W-1:0]    res_key,
    output logic [tkpc_pkg::EV_W-1:0]     res_event,
    output logic                          res_touched
);

    logic [tkpc_pkg::SAMPLE_W-1:0] baseline_reg [tkpc_pkg::NUM_KEYS];
    logic [tkpc_pkg::ST_W-1:0]     state_reg    [tkpc_pkg::NUM_KEYS];
    logic [tkpc_pkg::HOLD_W-1:0]   hold_reg     [tkpc_pkg::NUM_KEYS];

    logic [tkpc_pkg::ST_W-1:0]     state_next;
    logic [tkpc_pkg::HOLD_W-1:0]   hold_next;

    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [tkpc_pkg::KEY_W-1:0]    res_key_reg;
    logic [tkpc_pkg::EV_W-1:0]     res_event_reg;
    logic [tkpc_pkg::EV_W-1:0]     res_event_next;
    logic                          res_touched_reg;
    logic                          res_touched_next;

    logic [tkpc_pkg::KEY_IDX_W-1:0] idx;
    logic [tkpc_pkg::SAMPLE_W-1:0]  base;
    logic [tkpc_pkg::SAMPLE_W-1:0]  diff;
    logic                           active;
    logic [tkpc_pkg::HOLD_W:0]      sum;
    logic [tkpc_pkg::HOLD_W-1:0]    hold_sat;
    logic                           take;
    logic                           is_poll;

    assign in_ready = !res_valid_reg || res_ready;
    assign take     = in_valid && in_ready;
    assign is_poll  = (in_item.op == tkpc_pkg::OP_POLL);

    assign idx  = tkpc_pkg::key_index(in_item.key);
    assign base = baseline_reg[idx];

    // absolute distance from the idle reading
    assign diff   = (in_item.sample >= base) ? (in_item.sample - base)
                                             : (base - in_item.sample);
    assign active = (diff > cfg.threshold);

    // saturating hold accumulation
    assign sum      = {1'b0, hold_reg[idx]} + (tkpc_pkg::HOLD_W + 1)'(cfg.step);
    assign hold_sat = sum[tkpc_pkg::HOLD_W] ? {tkpc_pkg::HOLD_W{1'b1}}
                                            : sum[tkpc_pkg::HOLD_W-1:0];

    always_comb
    begin
        state_next     = state_reg[idx];
        hold_next      = hold_reg[idx];
        res_event_next = tkpc_pkg::EV_NONE;
        unique case (state_reg[idx])
            tkpc_pkg::ST_HOLDING:
            begin
                if (!active)
                begin
                    hold_next      = '0;
                    state_next     = tkpc_pkg::ST_RELEASED;
                    res_event_next = tkpc_pkg::EV_SHORT;
                end
                else if (hold_sat > cfg.limit)
                begin
                    hold_next      = '0;
                    state_next     = tkpc_pkg::ST_LONG_HOLD;
                    res_event_next = tkpc_pkg::EV_LONG;
                end
                else
                begin
                    hold_next = hold_sat;
                end
            end
            tkpc_pkg::ST_LONG_HOLD:
            begin
                if (!active)
                    state_next = tkpc_pkg::ST_RELEASED;
            end
            default:
            begin
                if (active)
                begin
                    state_next = tkpc_pkg::ST_HOLDING;
                    hold_next  = hold_sat;
                end
            end
        endcase
        if (!is_poll)
            res_event_next = tkpc_pkg::EV_NONE;
        res_touched_next = is_poll && active;
    end

    always_comb
    begin
        if (take)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int k = 0; k < tkpc_pkg::NUM_KEYS; k++)
            begin
                baseline_reg[k] <= '0;
                state_reg[k]    <= tkpc_pkg::ST_RELEASED;
                hold_reg[k]     <= '0;
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take && (in_item.op == tkpc_pkg::OP_CALIBRATE))
                baseline_reg[idx] <= in_item.sample;
            if (take && is_poll)
            begin
                state_reg[idx] <= state_next;
                hold_reg[idx]  <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_key_reg     <= in_item.key;
            res_event_reg   <= res_event_next;
            res_touched_reg <= res_touched_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_key     = res_key_reg;
    assign res_event   = res_event_reg;
    assign res_touched = res_touched_reg;

endmodule
